// ===== rtl/core/button_gesture_mode_fsm_unit_macros.svh =====
`ifndef BUTTON_GESTURE_MODE_FSM_UNIT_MACROS_SVH
`define BUTTON_GESTURE_MODE_FSM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BGM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bgm assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BGM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bgm assertion failed");

`endif

// ===== rtl/core/bgm_pkg.sv =====
`timescale 1ns / 1ps
package bgm_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CLICK_W    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD_SHORT   = 8'd0,
		CFG_HOLD_LONG    = 8'd1,
		CFG_CLICK_WINDOW = 8'd2,
		CFG_IDLE_LIMIT   = 8'd3
	} cfg_idx_t;

	localparam logic [CFG_DATA_W-1:0] HOLD_SHORT_RST   = 16'd3000;
	localparam logic [CFG_DATA_W-1:0] HOLD_LONG_RST    = 16'd7000;
	localparam logic [CFG_DATA_W-1:0] CLICK_WINDOW_RST = 16'd300;
	localparam logic [CFG_DATA_W-1:0] IDLE_LIMIT_RST   = 16'd10000;

	localparam logic [CLICK_W-1:0] CLICK_MAX = 3'd7;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_USER  = 2'd1,
		MODE_MENU  = 2'd2,
		MODE_ALERT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		HOLD_NONE         = 2'd0,
		HOLD_OPEN_MENU    = 2'd1,
		HOLD_REMOVE_USER  = 2'd2,
		HOLD_DISMISS_MENU = 2'd3
	} hold_act_t;

	typedef enum logic [1:0] {
		CLICK_NONE      = 2'd0,
		CLICK_CONFIRM   = 2'd1,
		CLICK_DISMISS   = 2'd2,
		CLICK_NEXT_USER = 2'd3
	} click_act_t;

	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_ALERT = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] hold_short;
		logic [CFG_DATA_W-1:0] hold_long;
		logic [CFG_DATA_W-1:0] click_window;
		logic [CFG_DATA_W-1:0] idle_limit;
	} cfg_regs_t;

	typedef struct packed {
		mode_t      mode;
		hold_act_t  hold_action;
		click_act_t click_action;
		logic       add_user;
	} result_t;

endpackage

// ===== rtl/core/bgm_if.sv =====
`timescale 1ns / 1ps
interface bgm_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic button_pressed;

	modport source (output valid, output cmd, output button_pressed, input ready);
	modport sink (input valid, input cmd, input button_pressed, output ready);
endinterface

interface bgm_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [1:0] hold_action;
	logic [1:0] click_action;
	logic       add_user;

	modport source (output valid, output mode, output hold_action, output click_action,
		output add_user, input ready);
	modport sink (input valid, input mode, input hold_action, input click_action,
		input add_user, output ready);
endinterface

interface bgm_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bgm_cfg.sv =====
`timescale 1ns / 1ps
module bgm_cfg
	import bgm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bgm_cfg_if.sink    cfg,
	output cfg_regs_t  regs
);

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hold_short   <= HOLD_SHORT_RST;
			regs_q.hold_long    <= HOLD_LONG_RST;
			regs_q.click_window <= CLICK_WINDOW_RST;
			regs_q.idle_limit   <= IDLE_LIMIT_RST;
		end else if (cfg.valid) begin
			// unknown indexes drop silently
			case (cfg.index)
				CFG_HOLD_SHORT:   regs_q.hold_short   <= cfg.data;
				CFG_HOLD_LONG:    regs_q.hold_long    <= cfg.data;
				CFG_CLICK_WINDOW: regs_q.click_window <= cfg.data;
				CFG_IDLE_LIMIT:   regs_q.idle_limit   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/bgm_engine.sv =====
`timescale 1ns / 1ps
module bgm_engine
	import bgm_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  logic      cmd,
	input  logic      pressed,
	input  cfg_regs_t regs,
	output result_t   result
);

	localparam int CW = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

	mode_t                 mode_q, mode_d;
	logic                  hold_q, hold_d;
	logic [TIMER_BITS-1:0] hold_el_q, hold_el_d;
	logic [CLICK_W-1:0]    clicks_q, clicks_d;
	logic [TIMER_BITS-1:0] since_rel_q, since_rel_d;
	logic [TIMER_BITS-1:0] since_act_q, since_act_d;
	hold_act_t             hold_act;
	click_act_t            click_act;
	logic                  add;

	function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
		return (&v) ? v : v + TIMER_BITS'(1);
	endfunction

	// next state
	always_comb begin
		mode_d      = mode_q;
		hold_d      = hold_q;
		hold_el_d   = hold_el_q;
		clicks_d    = clicks_q;
		since_rel_d = since_rel_q;
		since_act_d = since_act_q;
		hold_act    = HOLD_NONE;
		click_act   = CLICK_NONE;
		add         = 1'b0;
		if (cmd == CMD_ALERT) begin
			mode_d = MODE_ALERT;
		end else begin
			since_rel_d = sat_inc(since_rel_q);
			since_act_d = sat_inc(since_act_q);
			if (hold_q)
				hold_el_d = sat_inc(hold_el_q);
			if (pressed) begin
				if (!hold_q) begin
					hold_d    = 1'b1;
					hold_el_d = '0;
				end
				since_act_d = '0;
				case (mode_q)
					MODE_NONE: begin
						if (CW'(hold_el_d) >= CW'(regs.hold_short)) begin
							mode_d   = MODE_MENU;
							hold_act = HOLD_OPEN_MENU;
							hold_d   = 1'b0;
						end
					end
					MODE_USER: begin
						if (CW'(hold_el_d) >= CW'(regs.hold_long)) begin
							mode_d   = MODE_NONE;
							hold_act = HOLD_REMOVE_USER;
							hold_d   = 1'b0;
						end
					end
					MODE_MENU: begin
						if (CW'(hold_el_d) >= CW'(regs.hold_short)) begin
							mode_d   = MODE_NONE;
							hold_act = HOLD_DISMISS_MENU;
							hold_d   = 1'b0;
						end
					end
					default: ;
				endcase
			end else if (hold_q) begin
				hold_d      = 1'b0;
				since_rel_d = '0;
				if (clicks_q != CLICK_MAX)
					clicks_d = clicks_q + CLICK_W'(1);
			end

			// resolve clicks once the release gap exceeds the window
			if (clicks_d != '0 && CW'(since_rel_d) > CW'(regs.click_window)) begin
				if (mode_d == MODE_ALERT) begin
					if (clicks_d == CLICK_W'(1)) begin
						mode_d    = MODE_USER;
						click_act = CLICK_CONFIRM;
					end else if (clicks_d == CLICK_W'(2)) begin
						mode_d    = MODE_USER;
						click_act = CLICK_DISMISS;
					end
				end else if (mode_d == MODE_MENU && clicks_d == CLICK_W'(1)) begin
					click_act = CLICK_NEXT_USER;
				end
				clicks_d    = '0;
				since_act_d = '0;
			end

			if (mode_d == MODE_MENU && CW'(since_act_d) >= CW'(regs.idle_limit)) begin
				mode_d      = MODE_USER;
				add         = 1'b1;
				since_act_d = '0;
			end
		end
	end

	// outputs
	always_comb begin
		result.mode         = mode_d;
		result.hold_action  = hold_act;
		result.click_action = click_act;
		result.add_user     = add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NONE;
			hold_q      <= 1'b0;
			hold_el_q   <= '0;
			clicks_q    <= '0;
			since_rel_q <= '0;
			since_act_q <= '0;
		end else if (advance) begin
			mode_q      <= mode_d;
			hold_q      <= hold_d;
			hold_el_q   <= hold_el_d;
			clicks_q    <= clicks_d;
			since_rel_q <= since_rel_d;
			since_act_q <= since_act_d;
		end
	end

endmodule

// ===== rtl/core/button_gesture_mode_fsm_unit.sv =====
`timescale 1ns / 1ps
// Button gesture and UI mode controller. Each request is either a one
// millisecond tick carrying the debounced button level or an alert command;
// each yields exactly one result with the new mode and any hold, click or
// add-user action. Throughput is one request per clock cycle unless output
// stalls: a request is captured in an input register, the mode machine
// and its counters update in a single pass as it moves into the result
// register, and the result waits there until taken while the next request
// is already captured. Elapsed counters are TIMER_BITS wide and saturate.
// Configuration registers: 0 short hold, 1 long hold, 2 click window,
// 3 menu idle limit; write only while no request is in flight.
module button_gesture_mode_fsm_unit
	import bgm_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bgm_cfg_if.sink    cfg,
	bgm_in_if.sink     item_in,
	bgm_out_if.source  item_out
);

	`include "button_gesture_mode_fsm_unit_macros.svh"

	cfg_regs_t regs;
	result_t   result;
	result_t   result_q;
	logic      valid_s1;
	logic      cmd_s1;
	logic      pressed_s1;
	logic      out_valid_q;
	logic      advance;

	assign advance       = valid_s1 && (!out_valid_q || item_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_in.ready)
			valid_s1 <= item_in.valid;
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			cmd_s1     <= item_in.cmd;
			pressed_s1 <= item_in.button_pressed;
		end
	end

	bgm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bgm_engine #(
		.TIMER_BITS (TIMER_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd     (cmd_s1),
		.pressed (pressed_s1),
		.regs    (regs),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (item_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result;
	end

	assign item_out.valid        = out_valid_q;
	assign item_out.mode         = result_q.mode;
	assign item_out.hold_action  = result_q.hold_action;
	assign item_out.click_action = result_q.click_action;
	assign item_out.add_user     = result_q.add_user;

	`BGM_ASSERT_NEXT(a_advance_fills, advance, out_valid_q)
	`BGM_ASSERT_IMP(a_open_to_menu, out_valid_q && result_q.hold_action == HOLD_OPEN_MENU,
		result_q.mode == MODE_MENU || result_q.mode == MODE_USER)
	`BGM_ASSERT_IMP(a_add_to_user, out_valid_q && result_q.add_user,
		result_q.mode == MODE_USER)
	`BGM_ASSERT_IMP(a_alert_click, out_valid_q && (result_q.click_action == CLICK_CONFIRM ||
		result_q.click_action == CLICK_DISMISS), result_q.mode == MODE_USER)

endmodule
